/* design/lrecho_pkg.sv */
// ----------------------------------------------------------------------------
// lrecho_pkg
// Shared constants, codes and types of the line receiver with echo.
// ----------------------------------------------------------------------------
package lrecho_pkg;

   localparam int unsigned LINE_DEPTH = 64;
   localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type LINE_LAST = idx_type'(LINE_DEPTH - 1);

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_READ    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   // one store write
   typedef struct packed {
      logic       en;
      idx_type    addr;
      logic [7:0] data;
   } wr_type;

   // result description of one accepted request
   typedef struct packed {
      logic       two;
      logic [7:0] echo_byte;
      logic       echo_valid;
      logic       line_ready;
      logic [6:0] line_length;
      logic       is_read;
      logic       in_range;
      logic       discarded;
      logic       dropped;
   } desc_type;

endpackage

/* design/lrecho_store.sv */
// ----------------------------------------------------------------------------
// lrecho_store
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lrecho_store (
   input  logic                clock,
   input  lrecho_pkg::wr_type  wr,
   input  logic                rd_en,
   input  lrecho_pkg::idx_type rd_addr,
   output logic [7:0]          rd_data_ff
);

   logic [7:0] mem [lrecho_pkg::LINE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* design/lrecho_ctrl.sv */
// ----------------------------------------------------------------------------
// lrecho_ctrl
// Line state: fill count, ready and receiving flags; store write generation.
// ----------------------------------------------------------------------------
module lrecho_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 acc,
   input  lrecho_pkg::mode_type mode,
   input  logic [7:0]           rx_byte,
   input  logic                 rx_err,
   output lrecho_pkg::wr_type   wr,
   output lrecho_pkg::desc_type desc,
   output logic                 nul_busy
);

   lrecho_pkg::idx_type fill_ff, fill_in, fill_eff;
   logic                ready_ff, ready_in;
   logic                recv_ff, recv_in;
   logic                nul_pend_ff, nul_pend_in;
   lrecho_pkg::idx_type nul_addr_ff, nul_addr_in;
   logic                is_eol;

   assign nul_busy = nul_pend_ff;
   assign fill_eff = recv_ff ? fill_ff : '0;
   assign is_eol   = (rx_byte == lrecho_pkg::CH_NL) || (rx_byte == lrecho_pkg::CH_CR);

   always_comb begin
      fill_in     = fill_ff;
      ready_in    = ready_ff;
      recv_in     = recv_ff;
      nul_pend_in = 1'b0;
      nul_addr_in = nul_addr_ff;
      wr          = '0;
      desc        = '0;

      if (nul_pend_ff) begin
         // second write of an end of line: the terminator
         wr.en   = 1'b1;
         wr.addr = nul_addr_ff;
         wr.data = lrecho_pkg::CH_NUL;
      end

      if (acc) begin
         unique case (mode)
            lrecho_pkg::MODE_BYTE: begin
               if (ready_ff) begin
                  desc.dropped = 1'b1;
               end else if (fill_eff >= lrecho_pkg::LINE_LAST) begin
                  // store full: terminate the line and drop the byte
                  fill_in      = lrecho_pkg::LINE_LAST;
                  ready_in     = 1'b1;
                  recv_in      = 1'b0;
                  wr.en        = 1'b1;
                  wr.addr      = lrecho_pkg::LINE_LAST;
                  wr.data      = lrecho_pkg::CH_NUL;
                  desc.dropped = 1'b1;
               end else if (rx_err) begin
                  fill_in        = '0;
                  ready_in       = 1'b0;
                  recv_in        = 1'b0;
                  desc.discarded = 1'b1;
               end else begin
                  wr.en   = 1'b1;
                  wr.addr = fill_eff;
                  wr.data = rx_byte;
                  desc.echo_valid = 1'b1;
                  if (is_eol) begin
                     fill_in        = fill_eff;
                     ready_in       = 1'b1;
                     recv_in        = 1'b0;
                     nul_pend_in    = 1'b1;
                     nul_addr_in    = fill_eff + 1'b1;
                     desc.two       = 1'b1;
                     desc.echo_byte = lrecho_pkg::CH_NL;
                  end else begin
                     fill_in        = fill_eff + 1'b1;
                     recv_in        = 1'b1;
                     desc.echo_byte = rx_byte;
                  end
               end
            end
            lrecho_pkg::MODE_RELEASE: begin
               ready_in = 1'b0;
               if (!recv_ff) begin
                  fill_in = '0;
               end
            end
            lrecho_pkg::MODE_READ: begin
               desc.is_read = 1'b1;
            end
            default: begin
            end
         endcase
      end

      desc.line_ready  = ready_in;
      desc.line_length = 7'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         ready_ff    <= 1'b0;
         recv_ff     <= 1'b0;
         nul_pend_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         ready_ff    <= ready_in;
         recv_ff     <= recv_in;
         nul_pend_ff <= nul_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      nul_addr_ff <= nul_addr_in;
   end

endmodule

/* design/lrecho_resp.sv */
// ----------------------------------------------------------------------------
// lrecho_resp
// Result stage and output register; splits an end of line into its echo pair.
// ----------------------------------------------------------------------------
module lrecho_resp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lrecho_pkg::desc_type desc,
   input  logic [7:0]           rd_data,
   output logic                 can_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_echo_byte,
   output logic                 rsp_echo_valid,
   output logic                 rsp_last,
   output logic                 rsp_line_ready,
   output logic [6:0]           rsp_line_length,
   output logic [7:0]           rsp_read_char,
   output logic                 rsp_line_discarded,
   output logic                 rsp_byte_dropped
);

   lrecho_pkg::desc_type s1_ff;
   logic                 s1_valid_ff;
   logic                 phase_ff;
   logic                 out_valid_ff;
   logic                 adv, finish;
   logic [7:0]           echo_in, rchar_in;
   logic                 last_in;

   logic [7:0] echo_ff, rchar_ff;
   logic       echo_valid_ff, last_ff, ready_ff, disc_ff, drop_ff;
   logic [6:0] len_ff;

   assign adv      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign finish   = adv && (!s1_ff.two || phase_ff);
   assign can_take = !s1_valid_ff || finish;

   assign last_in  = !s1_ff.two || phase_ff;
   assign echo_in  = (s1_ff.two && phase_ff) ? lrecho_pkg::CH_CR : s1_ff.echo_byte;
   assign rchar_in = (s1_ff.is_read && s1_ff.in_range) ? rd_data : 8'h00;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            s1_valid_ff <= 1'b1;
            phase_ff    <= 1'b0;
         end else if (finish) begin
            s1_valid_ff <= 1'b0;
         end else if (adv) begin
            phase_ff <= 1'b1;
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= desc;
      end
      if (adv) begin
         echo_ff       <= echo_in;
         echo_valid_ff <= s1_ff.echo_valid;
         last_ff       <= last_in;
         ready_ff      <= s1_ff.line_ready;
         len_ff        <= s1_ff.line_length;
         rchar_ff      <= rchar_in;
         disc_ff       <= s1_ff.discarded;
         drop_ff       <= s1_ff.dropped;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_echo_byte      = echo_ff;
   assign rsp_echo_valid     = echo_valid_ff;
   assign rsp_last           = last_ff;
   assign rsp_line_ready     = ready_ff;
   assign rsp_line_length    = len_ff;
   assign rsp_read_char      = rchar_ff;
   assign rsp_line_discarded = disc_ff;
   assign rsp_byte_dropped   = drop_ff;

endmodule

/* design/line_receiver_with_echo.sv */
// ----------------------------------------------------------------------------
// line_receiver_with_echo
// First result: registered in the result stage, then in the output register.
// One request per cycle while rsp_stall is low; an end of line gives two
// results and a second store write for the terminator, holding req_stall.
// Reset: line empty, standby; store contents stay undefined until written.
// ----------------------------------------------------------------------------
module line_receiver_with_echo (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_error,
   input  logic       req_overrun_error,
   input  logic       req_parity_error,
   input  logic [5:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_echo_valid,
   output logic       rsp_last,
   output logic       rsp_line_ready,
   output logic [6:0] rsp_line_length,
   output logic [7:0] rsp_read_char,
   output logic       rsp_line_discarded,
   output logic       rsp_byte_dropped
);

   lrecho_pkg::mode_type mode;
   lrecho_pkg::wr_type   wr;
   lrecho_pkg::desc_type desc, desc_full;
   logic                 acc, can_take, nul_busy, rd_en;
   logic [7:0]           rd_data;

   assign mode      = lrecho_pkg::mode_type'(req_mode);
   assign req_stall = !can_take || nul_busy;
   assign acc       = req_valid && !req_stall;
   assign rd_en     = acc && (mode == lrecho_pkg::MODE_READ);

   always_comb begin
      desc_full          = desc;
      desc_full.in_range = (32'(req_read_index) < lrecho_pkg::LINE_DEPTH);
   end

   lrecho_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .mode     (mode),
      .rx_byte  (req_rx_byte),
      .rx_err   (req_frame_error | req_overrun_error | req_parity_error),
      .wr       (wr),
      .desc     (desc),
      .nul_busy (nul_busy)
   );

   lrecho_store u_store (
      .clock      (clock),
      .wr         (wr),
      .rd_en      (rd_en),
      .rd_addr    (lrecho_pkg::idx_type'(req_read_index)),
      .rd_data_ff (rd_data)
   );

   lrecho_resp u_resp (
      .clock              (clock),
      .reset              (reset),
      .load               (acc),
      .desc               (desc_full),
      .rd_data            (rd_data),
      .can_take           (can_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_last           (rsp_last),
      .rsp_line_ready     (rsp_line_ready),
      .rsp_line_length    (rsp_line_length),
      .rsp_read_char      (rsp_read_char),
      .rsp_line_discarded (rsp_line_discarded),
      .rsp_byte_dropped   (rsp_byte_dropped)
   );

endmodule

/* design/lrecho_checker.sv */
// ----------------------------------------------------------------------------
// lrecho_checker
// Port-level checks of the line receiver with echo.
// ----------------------------------------------------------------------------
module lrecho_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_mode,
   input logic [7:0] req_rx_byte,
   input logic       req_frame_error,
   input logic       req_overrun_error,
   input logic       req_parity_error,
   input logic [5:0] req_read_index,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_echo_byte,
   input logic       rsp_echo_valid,
   input logic       rsp_last,
   input logic       rsp_line_ready,
   input logic [6:0] rsp_line_length,
   input logic [7:0] rsp_read_char,
   input logic       rsp_line_discarded,
   input logic       rsp_byte_dropped
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_byte) && $stable(rsp_last)
         && $stable(rsp_line_length) && $stable(rsp_read_char))
      else $error("stalled result changed");

   a_no_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_echo_valid |-> rsp_echo_byte == 8'h00)
      else $error("echo byte set without echo");

   // first of an echo pair is a newline on a now ready line
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_echo_valid && rsp_echo_byte == 8'h0A && rsp_line_ready)
      else $error("bad first result of echo pair");

   a_discard_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_discarded |-> !rsp_line_ready && rsp_line_length == 7'd0
         && !rsp_echo_valid && !rsp_byte_dropped)
      else $error("discarded line not cleared");

   a_read_no_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_char != 8'h00 |-> !rsp_echo_valid && rsp_last)
      else $error("read data on an echo result");

endmodule

bind line_receiver_with_echo lrecho_checker u_lrecho_checker (.*);

/* dv/line_receiver_with_echo_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_receiver_with_echo_tb
// Self-checking bench for the line receiver: directed and random requests and response
// stalls drive the block, and a scoreboard mirrors the line store and flags.
// ----------------------------------------------------------------------------
module line_receiver_with_echo_tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned IDLE_PCT     = 34;

   typedef struct {
      lrecho_pkg::mode_type mode;
      logic [7:0]           rx_byte;
      logic                 frame_error;
      logic                 overrun_error;
      logic                 parity_error;
      logic [5:0]           read_index;
   } rx_request_type;

   typedef struct {
      logic [7:0] echo_byte;
      logic       echo_valid;
      logic       last;
      logic       line_ready;
      logic [6:0] line_length;
      logic [7:0] read_char;
      logic       line_discarded;
      logic       byte_dropped;
   } echo_result_type;

   class line_scoreboard;
      logic [7:0]      store_mem [lrecho_pkg::LINE_DEPTH];
      bit              written [lrecho_pkg::LINE_DEPTH];
      int unsigned     fill;
      bit              ready;
      bit              receiving;
      echo_result_type echo_expected [$];
      int unsigned     errors;

      function new();
         fill      = 0;
         ready     = 1'b0;
         receiving = 1'b0;
         errors    = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void store_char(int unsigned idx, logic [7:0] ch);
         store_mem[idx] = ch;
         written[idx]   = 1'b1;
      endfunction

      // status fields follow the flags after the request
      function void push_result(logic [7:0] echo, bit valid, bit last,
                                logic [7:0] rchar, bit discarded, bit dropped);
         echo_result_type r;
         r.echo_byte      = echo;
         r.echo_valid     = valid;
         r.last           = last;
         r.line_ready     = ready;
         r.line_length    = fill[6:0];
         r.read_char      = rchar;
         r.line_discarded = discarded;
         r.byte_dropped   = dropped;
         echo_expected.push_back(r);
      endfunction

      function void note_request(rx_request_type q);
         case (q.mode)
            lrecho_pkg::MODE_BYTE: begin
               if (ready) begin
                  push_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
               end else begin
                  if (!receiving) begin
                     fill      = 0;
                     receiving = 1'b1;
                  end
                  if (fill >= lrecho_pkg::LINE_DEPTH - 1) begin
                     // store full: terminate, drop the byte, ignore its errors
                     fill = lrecho_pkg::LINE_DEPTH - 1;
                     store_char(lrecho_pkg::LINE_DEPTH - 1, lrecho_pkg::CH_NUL);
                     ready     = 1'b1;
                     receiving = 1'b0;
                     push_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
                  end else if (q.frame_error || q.overrun_error || q.parity_error) begin
                     fill      = 0;
                     ready     = 1'b0;
                     receiving = 1'b0;
                     push_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
                  end else begin
                     store_char(fill, q.rx_byte);
                     if (q.rx_byte == lrecho_pkg::CH_NL || q.rx_byte == lrecho_pkg::CH_CR)
                     begin
                        store_char(fill + 1, lrecho_pkg::CH_NUL);
                        ready     = 1'b1;
                        receiving = 1'b0;
                        push_result(lrecho_pkg::CH_NL, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
                        push_result(lrecho_pkg::CH_CR, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                     end else begin
                        fill++;
                        push_result(q.rx_byte, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                     end
                  end
               end
            end
            lrecho_pkg::MODE_RELEASE: begin
               ready = 1'b0;
               if (!receiving) fill = 0;
               push_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
            end
            lrecho_pkg::MODE_READ: begin
               push_result(8'h00, 1'b0, 1'b1, store_mem[q.read_index], 1'b0, 1'b0);
            end
            default: begin
               push_result(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
            end
         endcase
      endfunction

      function void field_check(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(echo_result_type got);
         echo_result_type want;
         if (echo_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual echo=%0h valid=%0b",
                     $time, got.echo_byte, got.echo_valid);
            return;
         end
         want = echo_expected.pop_front();
         field_check("echo_byte", want.echo_byte, got.echo_byte);
         field_check("echo_valid", 8'(want.echo_valid), 8'(got.echo_valid));
         field_check("last", 8'(want.last), 8'(got.last));
         field_check("line_ready", 8'(want.line_ready), 8'(got.line_ready));
         field_check("line_length", 8'(want.line_length), 8'(got.line_length));
         field_check("read_char", want.read_char, got.read_char);
         field_check("line_discarded", 8'(want.line_discarded), 8'(got.line_discarded));
         field_check("byte_dropped", 8'(want.byte_dropped), 8'(got.byte_dropped));
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_mode;
   logic [7:0] req_rx_byte;
   logic       req_frame_error;
   logic       req_overrun_error;
   logic       req_parity_error;
   logic [5:0] req_read_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_echo_byte;
   logic       rsp_echo_valid;
   logic       rsp_last;
   logic       rsp_line_ready;
   logic [6:0] rsp_line_length;
   logic [7:0] rsp_read_char;
   logic       rsp_line_discarded;
   logic       rsp_byte_dropped;

   line_scoreboard sb;
   bit             steady;
   int unsigned    sent_count;
   int unsigned    cycle_count;

   line_receiver_with_echo u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_rx_byte        (req_rx_byte),
      .req_frame_error    (req_frame_error),
      .req_overrun_error  (req_overrun_error),
      .req_parity_error   (req_parity_error),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_last           (rsp_last),
      .rsp_line_ready     (rsp_line_ready),
      .rsp_line_length    (rsp_line_length),
      .rsp_read_char      (rsp_read_char),
      .rsp_line_discarded (rsp_line_discarded),
      .rsp_byte_dropped   (rsp_byte_dropped)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      echo_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.echo_byte      = rsp_echo_byte;
         got.echo_valid     = rsp_echo_valid;
         got.last           = rsp_last;
         got.line_ready     = rsp_line_ready;
         got.line_length    = rsp_line_length;
         got.read_char      = rsp_read_char;
         got.line_discarded = rsp_line_discarded;
         got.byte_dropped   = rsp_byte_dropped;
         sb.check_result(got);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_receiver_with_echo regression: fail");
      $finish;
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == lrecho_pkg::CH_NL || b == lrecho_pkg::CH_CR);
      return b;
   endfunction

   function automatic rx_request_type rand_request(lrecho_pkg::mode_type m);
      rx_request_type q;
      q.mode          = m;
      q.rx_byte       = 8'($urandom_range(0, 255));
      q.frame_error   = ($urandom_range(0, 99) < 15);
      q.overrun_error = ($urandom_range(0, 99) < 15);
      q.parity_error  = ($urandom_range(0, 99) < 15);
      q.read_index    = 6'($urandom_range(0, 63));
      return q;
   endfunction

   task automatic send(rx_request_type q);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_mode          = q.mode;
      req_rx_byte       = q.rx_byte;
      req_frame_error   = q.frame_error;
      req_overrun_error = q.overrun_error;
      req_parity_error  = q.parity_error;
      req_read_index    = q.read_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(q);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic put_byte(logic [7:0] b, logic fe = 1'b0, logic oe = 1'b0,
                           logic pe = 1'b0);
      rx_request_type q;
      q               = rand_request(lrecho_pkg::MODE_BYTE);
      q.rx_byte       = b;
      q.frame_error   = fe;
      q.overrun_error = oe;
      q.parity_error  = pe;
      send(q);
   endtask

   task automatic put_mode(lrecho_pkg::mode_type m, logic [5:0] idx = 6'd0);
      rx_request_type q;
      q = rand_request(m);
      if (m == lrecho_pkg::MODE_READ) q.read_index = idx;
      send(q);
   endtask

   // read only entries that have been written at some point
   task automatic read_some(int unsigned n);
      int unsigned ok_idx [$];
      for (int unsigned k = 0; k < n; k++) begin
         ok_idx.delete();
         for (int unsigned i = 0; i < lrecho_pkg::LINE_DEPTH; i++)
            if (sb.written[i]) ok_idx.push_back(i);
         if (ok_idx.size() == 0) return;
         put_mode(lrecho_pkg::MODE_READ, 6'(ok_idx[$urandom_range(0, ok_idx.size() - 1)]));
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.echo_expected.size() != 0) @(negedge clock);
   endtask

   task automatic line_sequence(int unsigned len, bit full);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 3) begin
            // broken line: an error byte discards what is held
            put_byte(plain_byte(), 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
            return;
         end
         put_byte(plain_byte());
      end
      if (full) begin
         send(rand_request(lrecho_pkg::MODE_BYTE));
      end else begin
         if ($urandom_range(0, 9) == 0)
            put_byte($urandom_range(0, 1) ? lrecho_pkg::CH_NL : lrecho_pkg::CH_CR,
                     1'b0, 1'b0, 1'b1);
         else
            put_byte($urandom_range(0, 1) ? lrecho_pkg::CH_NL : lrecho_pkg::CH_CR);
      end
      repeat ($urandom_range(0, 2)) send(rand_request(lrecho_pkg::MODE_BYTE));
      read_some($urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0) put_mode(lrecho_pkg::MODE_RELEASE);
   endtask

   task automatic noise_burst();
      lrecho_pkg::mode_type m;
      repeat ($urandom_range(1, 4)) begin
         m = lrecho_pkg::mode_type'($urandom_range(0, 3));
         if (m == lrecho_pkg::MODE_READ) read_some(1);
         else send(rand_request(m));
      end
   endtask

   initial begin
      int unsigned pick;
      bit          first_pass;
      sb                = new();
      steady            = 1'b0;
      sent_count        = 0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = lrecho_pkg::MODE_BYTE;
      req_rx_byte       = 8'h00;
      req_frame_error   = 1'b0;
      req_overrun_error = 1'b0;
      req_parity_error  = 1'b0;
      req_read_index    = 6'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      put_byte(8'h41);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_mode(lrecho_pkg::MODE_READ, 6'd0);
      put_mode(lrecho_pkg::MODE_READ, 6'd2);
      put_byte(8'h55, 1'b1, 1'b0, 1'b0);
      put_byte(8'h78);
      put_byte(8'hAA, 1'b0, 1'b1, 1'b0);
      put_byte(8'h79);
      put_byte(8'h00, 1'b0, 1'b0, 1'b1);
      put_byte(8'hFF, 1'b1, 1'b1, 1'b1);      // error in standby
      put_mode(lrecho_pkg::MODE_RELEASE);
      put_byte(8'h68);
      put_mode(lrecho_pkg::MODE_RELEASE);     // release while assembling
      put_byte(8'h69);
      put_byte(lrecho_pkg::CH_NL);
      put_byte(8'h3F, 1'b1, 1'b1, 1'b1);      // ignored while ready
      put_mode(lrecho_pkg::MODE_NONE);
      put_mode(lrecho_pkg::MODE_READ, 6'd2);
      put_mode(lrecho_pkg::MODE_READ, 6'd3);
      put_mode(lrecho_pkg::MODE_RELEASE);
      put_byte(lrecho_pkg::CH_CR);            // empty line
      put_mode(lrecho_pkg::MODE_READ, 6'd1);
      put_mode(lrecho_pkg::MODE_RELEASE);
      drain();

      sent_count = 0;
      first_pass = 1'b1;
      while (sent_count < RANDOM_ITEMS) begin
         steady = (sent_count >= 250 && sent_count < 350);
         if (sent_count >= 450 && sent_count < 460) drain();
         pick = $urandom_range(0, 19);
         if (first_pass || pick == 0)
            line_sequence(lrecho_pkg::LINE_DEPTH - 1, 1'b1);
         else if (pick == 1)
            line_sequence(lrecho_pkg::LINE_DEPTH - 2, 1'b0);
         else if (pick < 15)
            line_sequence($urandom_range(0, 12), 1'b0);
         else
            noise_burst();
         first_pass = 1'b0;
      end
      steady = 1'b0;
      drain();
      repeat (8) @(negedge clock);

      if (sb.errors == 0 && sb.echo_expected.size() == 0)
         $display("line_receiver_with_echo regression: pass");
      else
         $display("line_receiver_with_echo regression: fail");
      $finish;
   end

endmodule
